[rtl/mse_pkg.sv]
package mse_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS,
        S_RUN,
        S_READ,
        S_MERGE,
        S_OUT_READ,
        S_OUT_CAPTURE,
        S_OUT_HOLD
    } mse_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // store an accepted key
        logic sort_start;  // first pass: run width one, source buffer a
        logic run_init;    // restart at the first pair of runs
        logic seg_init;    // set up the next pair of runs
        logic seg_next;    // step past the finished pair
        logic pass_next;   // swap buffers and double the run width
        logic merge_wr;    // pick the smaller head and write it out
        logic out_init;    // start the readout
        logic out_sel;     // read port follows the readout index
        logic out_capture; // load the result register
        logic out_next;    // step to the next sorted key
        logic set_done;    // last key delivered, empty the engine
    } mse_cmd_t;

    typedef struct packed {
        logic pass_more;   // run width below the set size
        logic run_more;    // another pair of runs in this pass
        logic seg_done;    // every key of this pair written
        logic out_last;    // readout index at the final key
    } mse_status_t;

endpackage

[rtl/merge_sort_engine_core.sv]
// channel   handshake              payload
// input     in_valid / in_stall    key, final_key
// output    out_valid / out_stall  sorted_key, end_of_set
//
// loading takes one cycle per key; the key with final_key set closes the set
// sorting: ceil(log2 n) passes, each merging pairs of runs with a single compare
// on the run heads read from the two read ports of the source buffer
// readout: each sorted key is read, captured and then held for as long as the output is stalled
// input is stalled from the closing key until the last sorted key is taken
// reset clears the controller, key count and buffer select; buffers are not cleared
module merge_sort_engine_core
    import mse_pkg::*;
    #(
    parameter int MAX_KEYS = 64
    )
    (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [KEY_W-1:0] key,
    input  logic             final_key,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [KEY_W-1:0] sorted_key,
    output logic             end_of_set
    );

    mse_cmd_t    cmd;
    mse_status_t status;

    mse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .final_key (final_key),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mse_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .key        (key),
        .status     (status),
        .sorted_key (sorted_key),
        .end_of_set (end_of_set)
    );

    // no loading while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while sorted keys pending");

    // closing key starts the sort
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && final_key) |=> (in_stall && !out_valid))
        else $error("sort did not start on closing key");

    // after the last key of a set the engine is ready to load
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && end_of_set) |=> (!out_valid && !in_stall))
        else $error("engine not back to loading after last key");

    // merge never writes past the end of the set
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_wr |-> (u_dp.k_reg < u_dp.count_reg))
        else $error("merge write beyond set size");

endmodule

[rtl/mse_ram.sv]
module mse_ram
    #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

[rtl/mse_ctrl.sv]
module mse_ctrl
    import mse_pkg::*;
    (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        final_key,
    input  logic        out_stall,
    input  mse_status_t status,
    output logic        in_stall,
    output logic        out_valid,
    output mse_cmd_t    cmd
    );

    mse_state_t state_reg;
    mse_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (final_key)
                    begin
                        cmd.sort_start = 1'b1;
                        state_next     = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                if (status.pass_more)
                begin
                    cmd.run_init = 1'b1;
                    state_next   = S_RUN;
                end
                else
                begin
                    cmd.out_init = 1'b1;
                    state_next   = S_OUT_READ;
                end
            end
            S_RUN:
            begin
                if (status.run_more)
                begin
                    cmd.seg_init = 1'b1;
                    state_next   = S_READ;
                end
                else
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = S_PASS;
                end
            end
            S_READ:
            begin
                if (status.seg_done)
                begin
                    cmd.seg_next = 1'b1;
                    state_next   = S_RUN;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.merge_wr = 1'b1;
                state_next   = S_READ;
            end
            S_OUT_READ:
            begin
                cmd.out_sel = 1'b1;
                state_next  = S_OUT_CAPTURE;
            end
            S_OUT_CAPTURE:
            begin
                cmd.out_capture = 1'b1;
                state_next      = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (status.out_last)
                    begin
                        cmd.set_done = 1'b1;
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = S_OUT_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

[rtl/mse_dp.sv]
module mse_dp
    import mse_pkg::*;
    #(
    parameter int MAX_KEYS = 64
    )
    (
    input  logic              clk,
    input  logic              rst_n,
    input  mse_cmd_t          cmd,
    input  logic [KEY_W-1:0]  key,
    output mse_status_t       status,
    output logic [KEY_W-1:0]  sorted_key,
    output logic              end_of_set
    );

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int AW = $clog2(MAX_KEYS);

    logic [CW-1:0]    count_reg;
    logic             src_b_reg;
    logic [CW:0]      width_reg;
    logic [CW-1:0]    lo_reg;
    logic [CW-1:0]    mid_reg;
    logic [CW-1:0]    hi_reg;
    logic [CW-1:0]    i_reg;
    logic [CW-1:0]    j_reg;
    logic [CW-1:0]    k_reg;
    logic [KEY_W-1:0] sorted_key_reg;
    logic             end_of_set_reg;

    logic             full;
    logic [CW+1:0]    mid_sum;
    logic [CW+1:0]    hi_sum;
    logic [CW-1:0]    mid_clamp;
    logic [CW-1:0]    hi_clamp;
    logic [CW-1:0]    k_plus;
    logic             take_left;
    logic [KEY_W-1:0] left_key;
    logic [KEY_W-1:0] right_key;
    logic [KEY_W-1:0] merge_key;

    logic             we_a;
    logic             we_b;
    logic [AW-1:0]    waddr_a;
    logic [KEY_W-1:0] wdata_a;
    logic [AW-1:0]    raddr0;
    logic [AW-1:0]    raddr1;
    logic [KEY_W-1:0] rd_a0;
    logic [KEY_W-1:0] rd_a1;
    logic [KEY_W-1:0] rd_b0;
    logic [KEY_W-1:0] rd_b1;

    assign full      = (count_reg == CW'(MAX_KEYS));
    assign mid_sum   = {2'b00, lo_reg} + {1'b0, width_reg};
    assign hi_sum    = {2'b00, lo_reg} + {width_reg, 1'b0};
    assign mid_clamp = (mid_sum > {2'b00, count_reg}) ? count_reg : mid_sum[CW-1:0];
    assign hi_clamp  = (hi_sum > {2'b00, count_reg}) ? count_reg : hi_sum[CW-1:0];
    assign k_plus    = k_reg + CW'(1);

    // heads of both runs, from whichever buffer is the source this pass
    assign left_key  = src_b_reg ? rd_b0 : rd_a0;
    assign right_key = src_b_reg ? rd_b1 : rd_a1;
    // left run wins ties; an exhausted run never wins
    assign take_left = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (left_key <= right_key));
    assign merge_key = take_left ? left_key : right_key;

    assign we_a    = (cmd.load && !full) || (cmd.merge_wr && src_b_reg);
    assign we_b    = cmd.merge_wr && !src_b_reg;
    assign waddr_a = cmd.load ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wdata_a = cmd.load ? key : merge_key;
    assign raddr0  = cmd.out_sel ? k_reg[AW-1:0] : i_reg[AW-1:0];
    assign raddr1  = j_reg[AW-1:0];

    mse_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_ram_a (
        .clk    (clk),
        .we     (we_a),
        .waddr  (waddr_a),
        .wdata  (wdata_a),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rd_a0),
        .rdata1 (rd_a1)
    );

    mse_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_ram_b (
        .clk    (clk),
        .we     (we_b),
        .waddr  (k_reg[AW-1:0]),
        .wdata  (merge_key),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rd_b0),
        .rdata1 (rd_b1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            src_b_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_done)
            begin
                count_reg <= '0;
            end
            else if (cmd.load && !full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.sort_start)
            begin
                src_b_reg <= 1'b0;
            end
            else if (cmd.pass_next)
            begin
                src_b_reg <= !src_b_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_start)
        begin
            width_reg <= (CW+1)'(1);
        end
        else if (cmd.pass_next)
        begin
            width_reg <= {width_reg[CW-1:0], 1'b0};
        end

        if (cmd.run_init)
        begin
            lo_reg <= '0;
        end
        else if (cmd.seg_next)
        begin
            lo_reg <= hi_reg;
        end

        if (cmd.seg_init)
        begin
            mid_reg <= mid_clamp;
            hi_reg  <= hi_clamp;
            i_reg   <= lo_reg;
            j_reg   <= mid_clamp;
        end
        else if (cmd.merge_wr)
        begin
            if (take_left)
            begin
                i_reg <= i_reg + CW'(1);
            end
            else
            begin
                j_reg <= j_reg + CW'(1);
            end
        end

        if (cmd.seg_init)
        begin
            k_reg <= lo_reg;
        end
        else if (cmd.out_init)
        begin
            k_reg <= '0;
        end
        else if (cmd.merge_wr || cmd.out_next)
        begin
            k_reg <= k_plus;
        end

        if (cmd.out_capture)
        begin
            sorted_key_reg <= src_b_reg ? rd_b0 : rd_a0;
            end_of_set_reg <= (k_plus == count_reg);
        end
    end

    assign status.pass_more = (width_reg < {1'b0, count_reg});
    assign status.run_more  = (lo_reg < count_reg);
    assign status.seg_done  = (k_reg >= hi_reg);
    assign status.out_last  = (k_plus == count_reg);

    assign sorted_key = sorted_key_reg;
    assign end_of_set = end_of_set_reg;

endmodule

[dv/tb_merge_sort_engine_core.sv]
module tb_merge_sort_engine_core;
    import mse_pkg::*;

    localparam int MAX_KEYS = 64;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic [KEY_W-1:0] key        = '0;
    logic             final_key  = 1'b0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [KEY_W-1:0] sorted_key;
    logic             end_of_set;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    typedef struct {
        logic [KEY_W-1:0] key_val;
        logic             last_flag;
    } sorted_entry_t;

    class sorted_run_checker;
        logic [KEY_W-1:0] held_keys[$];
        sorted_entry_t    sorted_keys_due[$];
        int               errors = 0;

        // store one accepted key; on the closing key merge-sort the held set
        function void note_key(logic [KEY_W-1:0] k, logic fin);
            logic [KEY_W-1:0] src[$];
            logic [KEY_W-1:0] dst[$];
            sorted_entry_t    e;
            int n, w, lo, mid, hi, i, j;
            if (held_keys.size() < MAX_KEYS)
                held_keys.push_back(k);
            if (!fin)
                return;
            src = held_keys;
            n = src.size();
            // bottom-up passes, left run wins on equal keys
            for (w = 1; w < n; w = w * 2)
            begin
                dst = {};
                for (lo = 0; lo < n; lo = lo + 2 * w)
                begin
                    mid = (lo + w < n) ? lo + w : n;
                    hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
                    i = lo;
                    j = mid;
                    while (i < mid || j < hi)
                    begin
                        if (j >= hi || (i < mid && src[i] <= src[j]))
                        begin
                            dst.push_back(src[i]);
                            i++;
                        end
                        else
                        begin
                            dst.push_back(src[j]);
                            j++;
                        end
                    end
                end
                src = dst;
            end
            for (i = 0; i < n; i++)
            begin
                e.key_val   = src[i];
                e.last_flag = (i == n - 1);
                sorted_keys_due.push_back(e);
            end
            held_keys = {};
        endfunction

        function void check_result(logic [KEY_W-1:0] k, logic eos);
            sorted_entry_t e;
            if (sorted_keys_due.size() == 0)
            begin
                $error("result with nothing due: sorted_key %h end_of_set %b", k, eos);
                errors++;
                return;
            end
            e = sorted_keys_due.pop_front();
            if (k !== e.key_val)
            begin
                $error("sorted_key expected %h actual %h", e.key_val, k);
                errors++;
            end
            if (eos !== e.last_flag)
            begin
                $error("end_of_set expected %b actual %b", e.last_flag, eos);
                errors++;
            end
        endfunction
    endclass

    sorted_run_checker checker_h = new();

    merge_sort_engine_core #(
        .MAX_KEYS (MAX_KEYS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key        (key),
        .final_key  (final_key),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .end_of_set (end_of_set)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // output side: check each result transaction, stall at random or hold off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                checker_h.check_result(sorted_key, end_of_set);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 1500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_key(input logic [KEY_W-1:0] k, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            key       <= $urandom;
            final_key <= $urandom_range(0, 1);
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        key       <= k;
        final_key <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        checker_h.note_key(k, fin);
    endtask

    task automatic send_set(input logic [KEY_W-1:0] keys[$]);
        int i;
        for (i = 0; i < keys.size(); i++)
            send_key(keys[i], i == keys.size() - 1);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(0, 1) ? '1 : '0;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_phase(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
        endcase
    endtask

    initial
    begin
        logic [KEY_W-1:0] keys[$];
        int items, set_no, set_size, i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets: single keys at both extremes, reversed pair, all equal,
        // extremes with duplicates, already ascending
        set_phase(0);
        send_set('{32'h0000_0000});
        send_set('{32'hFFFF_FFFF});
        set_phase(3);
        send_set('{32'hFFFF_FFFF, 32'h0000_0000});
        send_set('{32'h7, 32'h7, 32'h7});
        set_phase(2);
        send_set('{32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1,
                   32'hFFFF_FFFE, 32'h0, 32'h5, 32'h5});
        set_phase(1);
        send_set('{32'h1, 32'h2, 32'h3, 32'h4});

        // keys already sent in the directed sets
        items  = 20;
        set_no = 0;
        while (items < 130)
        begin
            set_phase(set_no / 3);
            if (set_no == 2)
                set_size = $urandom_range(MAX_KEYS + 1, MAX_KEYS + 6);  // overflow
            else if ($urandom_range(0, 9) == 0)
                set_size = $urandom_range(13, 40);
            else
                set_size = $urandom_range(1, 12);
            // long hold-off so the engine holds its results and stalls its input
            if (set_no == 5)
                hold_req = 1'b1;
            keys = {};
            for (i = 0; i < set_size; i++)
                keys.push_back(pick_key());
            send_set(keys);
            items  += set_size;
            set_no++;
        end
        in_valid <= 1'b0;

        while (checker_h.sorted_keys_due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (checker_h.errors == 0 && checker_h.sorted_keys_due.size() == 0)
            $display("[merge_sort_engine_core] OK");
        else
            $display("[merge_sort_engine_core] ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("[merge_sort_engine_core] ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/mse_pkg.sv
rtl/mse_ram.sv
rtl/mse_ctrl.sv
rtl/mse_dp.sv
rtl/merge_sort_engine_core.sv
dv/tb_merge_sort_engine_core.sv
